FILE: src/vlc_delta_audio_unit_decoder_macros.svh
// Assertion helpers for the delta audio unit decoder.
// Both sample on the rising edge of clk and are quiet while rst is high.
`ifndef VLC_DELTA_AUDIO_UNIT_DECODER_MACROS_SVH
`define VLC_DELTA_AUDIO_UNIT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define VDAD_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication.
`define VDAD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define VDAD_ASSERT_NOW(label, cond, prop, msg)
`define VDAD_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

FILE: src/vdad_pkg.sv
package vdad_pkg;

  // Default sizes
  localparam int BIT_BUFFER_BITS_DEF  = 40;
  localparam int MAX_UNIT_SAMPLES_DEF = 65536;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int UNIT_W     = 17;
  localparam int SAMPLE_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Longest code: type, escape flag, escape pair, 8-bit run count
  localparam int CODE_W = 14;

  // Predictor preload lengths
  localparam int LOAD_MONO   = 16;
  localparam int LOAD_STEREO = 32;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULL   = 2'd2;
  // Unassigned mode: answered as accepted, changes nothing
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_SAMPLE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STARVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_RUNS = 2'd2;

  // Levels above this one behave as this one
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd5;
  // First level of the wide-field layout
  localparam logic [LEVEL_W-1:0] LEVEL_SPLIT = 3'd3;

  // Code types
  localparam logic [2:0] TYPE_RUN = 3'd0;
  localparam logic [2:0] TYPE_BIG = 3'd7;

  // Run escape values
  localparam logic [1:0] RUN_PAIR = 2'd2;
  localparam logic [1:0] RUN_ESC  = 2'd3;

  // One decoded code
  typedef struct packed {
    logic                ok;     // whole code is held
    logic                clear;  // predictor resets to zero
    logic                neg;    // subtract delta
    logic [3:0]          pos;    // code length in bits
    logic [7:0]          run;    // repeats after this sample
    logic [SAMPLE_W-1:0] delta;
  } code_t;

  // Decode the code at the bottom of the window; avail is the held count, clamped.
  function automatic code_t decode_code(input logic [CODE_W-1:0]  win,
                                        input logic [3:0]         avail,
                                        input logic [LEVEL_W-1:0] lvl,
                                        input logic               zr);
    code_t      c;
    logic [2:0] kind;
    logic       add;
    logic [3:0] nbits;
    logic [3:0] shamt;
    logic [7:0] field;
    logic [2:0] top;
    logic [7:0] mask;
    logic [7:0] rv;
    c     = '0;
    c.ok  = 1'b1;
    c.pos = 4'd3;
    add   = 1'b0;
    nbits = 4'd3;
    shamt = 4'd0;
    field = '0;
    kind  = win[2:0];
    rv    = win[13:6];
    if (avail < 4'd3) begin
      c.ok = 1'b0;
    end else begin
      unique case (kind)
        TYPE_RUN: begin
          // run length if zero runs are on: one flag bit, then a pair, then an 8-bit count
          if (zr) begin
            if (avail < 4'd4) begin
              c.ok = 1'b0;
            end else if (!win[3]) begin
              c.pos = 4'd4;
            end else if (avail < 4'd6) begin
              c.ok = 1'b0;
            end else if (win[5:4] != RUN_ESC) begin
              c.pos = 4'd6;
              c.run = (win[5:4] == RUN_PAIR) ? 8'd1 : 8'd0;
            end else if (avail < 4'(CODE_W)) begin
              c.ok = 1'b0;
            end else begin
              c.pos = 4'(CODE_W);
              c.run = (rv > 8'd1) ? rv - 8'd1 : 8'd0;
            end
          end
        end
        TYPE_BIG: begin
          // reset flag, else a large delta
          if (avail < 4'd4) begin
            c.ok = 1'b0;
          end else if (win[3]) begin
            c.clear = 1'b1;
            c.pos   = 4'd4;
          end else begin
            add   = 1'b1;
            nbits = (lvl >= LEVEL_SPLIT) ? 4'd8 : 4'd8 - {1'b0, lvl};
            shamt = (lvl >= LEVEL_SPLIT) ? 4'd9 : 4'd9 + {1'b0, lvl};
            field = win[11:4];
            c.pos = 4'd4 + nbits;
          end
        end
        default: begin
          // small delta scaled by type and level
          add   = 1'b1;
          nbits = (lvl >= LEVEL_SPLIT) ? 4'd3 + {1'b0, lvl} : 4'd5 - {1'b0, lvl};
          shamt = (lvl >= LEVEL_SPLIT) ? 4'd1 + {1'b0, kind}
                                       : 4'd2 + {1'b0, kind} + {1'b0, lvl};
          field = win[10:3];
          c.pos = 4'd3 + nbits;
        end
      endcase
      if (add && (avail < c.pos)) begin
        c.ok = 1'b0;
      end
    end
    // signed magnitude: top bit of the field is the sign
    top     = 3'(nbits - 4'd1);
    mask    = (8'd1 << top) - 8'd1;
    c.neg   = add & field[top];
    c.delta = add ? (SAMPLE_W'(field & mask) << shamt) : '0;
    return c;
  endfunction

endpackage

FILE: src/vlc_delta_audio_unit_decoder.sv
// Channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------
// item     | item_valid / item_stall    | mode, data_byte, unit_samples
// result   | result_valid / result_stall| sample, status, last
// config   | cfg_write                  | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; a taken item
// is held in the input register, then one pass through the decode logic loads
// the result register, which offers the beat. The decode reads the bit
// buffer and predictors and writes them back in the same pass, so each item
// sees the previous one's state.
// rst (synchronous) clears registers, unit state and the empty pipeline.
// A stalled result holds the input register; item_stall rises only then.
`include "vlc_delta_audio_unit_decoder_macros.svh"

module vlc_delta_audio_unit_decoder #(
  parameter int BIT_BUFFER_BITS  = vdad_pkg::BIT_BUFFER_BITS_DEF,
  parameter int MAX_UNIT_SAMPLES = vdad_pkg::MAX_UNIT_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [vdad_pkg::MODE_W-1:0]         mode,
  input  logic [vdad_pkg::BYTE_W-1:0]         data_byte,
  input  logic [vdad_pkg::UNIT_W-1:0]         unit_samples,
  input  logic                                cfg_write,
  input  logic [vdad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vdad_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [vdad_pkg::SAMPLE_W-1:0] sample,
  output logic [vdad_pkg::STATUS_W-1:0]       status,
  output logic                                last
);

  localparam int HELD_W = $clog2(BIT_BUFFER_BITS + 1);
  localparam int CNT_W  = $clog2(MAX_UNIT_SAMPLES + 1);
  localparam int SW     = vdad_pkg::SAMPLE_W;

  // Configuration
  logic [vdad_pkg::LEVEL_W-1:0] level_cfg;
  logic                         stereo;
  logic                         zero_runs;

  // Input register
  logic                        stage_valid;
  logic [vdad_pkg::MODE_W-1:0] stage_mode;
  logic [vdad_pkg::BYTE_W-1:0] stage_byte;
  logic [vdad_pkg::UNIT_W-1:0] stage_samples;

  // Unit state
  logic [BIT_BUFFER_BITS-1:0] bit_buffer,        bit_buffer_next;
  logic [HELD_W-1:0]          bits_held,         bits_held_next;
  logic [1:0][SW-1:0]         predictor,         predictor_next;
  logic                       channel_select,    channel_select_next;
  logic [7:0]                 run_remaining,     run_remaining_next;
  logic [CNT_W-1:0]           samples_emitted,   samples_emitted_next;
  logic [CNT_W-1:0]           unit_length,       unit_length_next;
  logic                       predictors_loaded, predictors_loaded_next;

  // Result beat being formed
  logic [SW-1:0]                 res_sample;
  logic [vdad_pkg::STATUS_W-1:0] res_status;
  logic                          res_last;

  logic out_free;
  logic fire;

  // Decode datapath
  logic [vdad_pkg::LEVEL_W-1:0] lvl;
  logic [HELD_W-1:0]            load_need;
  logic                         load_ok;
  logic [BIT_BUFFER_BITS-1:0]   buf_ld;
  logic [HELD_W-1:0]            held_ld;
  logic [3:0]                   avail;
  logic [SW-1:0]                p0_eff;
  logic [SW-1:0]                p1_eff;
  logic [SW-1:0]                pred_cur;
  logic [SW-1:0]                s_new;
  vdad_pkg::code_t              code;
  logic                         push_fit;
  logic [CNT_W-1:0]             emit_count;
  logic                         emit_last;

  // Pipeline handshake
  assign out_free   = !result_valid || !result_stall;
  assign fire       = stage_valid && out_free;
  assign item_stall = stage_valid && !out_free;

  // Level clamp and predictor preload view
  assign lvl       = (level_cfg > vdad_pkg::LEVEL_MAX) ? vdad_pkg::LEVEL_MAX
                                                       : level_cfg;
  assign load_need = stereo ? HELD_W'(vdad_pkg::LOAD_STEREO) : HELD_W'(vdad_pkg::LOAD_MONO);
  assign load_ok   = bits_held >= load_need;
  assign buf_ld    = predictors_loaded ? bit_buffer : (bit_buffer >> load_need);
  assign held_ld   = predictors_loaded ? bits_held : (bits_held - load_need);
  assign p0_eff    = predictors_loaded ? predictor[0] : bit_buffer[SW-1:0];
  assign p1_eff    = (!predictors_loaded && stereo) ? bit_buffer[2*SW-1:SW] : predictor[1];

  // Decode one code from the buffer bottom
  assign avail    = (held_ld > HELD_W'(15)) ? 4'hF : held_ld[3:0];
  assign code     = vdad_pkg::decode_code(buf_ld[vdad_pkg::CODE_W-1:0], avail, lvl, zero_runs);
  assign pred_cur = channel_select ? p1_eff : p0_eff;
  assign s_new    = code.clear ? '0 :
                    code.neg   ? (pred_cur - code.delta) : (pred_cur + code.delta);

  assign push_fit   = ({1'b0, bits_held} + (HELD_W + 1)'(vdad_pkg::BYTE_W))
                      <= (HELD_W + 1)'(BIT_BUFFER_BITS);
  assign emit_count = samples_emitted + CNT_W'(1);
  assign emit_last  = emit_count == unit_length;

  // Next state and result for the item in the input register
  always_comb begin
    bit_buffer_next        = bit_buffer;
    bits_held_next         = bits_held;
    predictor_next         = predictor;
    channel_select_next    = channel_select;
    run_remaining_next     = run_remaining;
    samples_emitted_next   = samples_emitted;
    unit_length_next       = unit_length;
    predictors_loaded_next = predictors_loaded;
    res_sample             = '0;
    res_status             = vdad_pkg::ST_ACCEPT;
    res_last               = 1'b0;
    unique case (stage_mode)
      vdad_pkg::MODE_START: begin
        // open a unit, saturate the count
        unit_length_next       = (stage_samples > vdad_pkg::UNIT_W'(MAX_UNIT_SAMPLES))
                                 ? CNT_W'(MAX_UNIT_SAMPLES) : CNT_W'(stage_samples);
        bit_buffer_next        = '0;
        bits_held_next         = '0;
        predictor_next         = '0;
        channel_select_next    = 1'b0;
        run_remaining_next     = '0;
        samples_emitted_next   = '0;
        predictors_loaded_next = 1'b0;
      end
      vdad_pkg::MODE_PUSH: begin
        // append above the held bits, drop the byte when full
        if (push_fit) begin
          bit_buffer_next = bit_buffer | (BIT_BUFFER_BITS'(stage_byte) << bits_held);
          bits_held_next  = bits_held + HELD_W'(vdad_pkg::BYTE_W);
        end else begin
          res_status = vdad_pkg::ST_FULL;
        end
      end
      vdad_pkg::MODE_PULL: begin
        if (samples_emitted >= unit_length) begin
          run_remaining_next = '0;
          res_status         = vdad_pkg::ST_DONE;
        end else if (run_remaining != 8'd0) begin
          // repeat the held sample
          run_remaining_next   = run_remaining - 8'd1;
          res_sample           = predictor[channel_select];
          res_status           = vdad_pkg::ST_SAMPLE;
          res_last             = emit_last;
          samples_emitted_next = emit_count;
          if (run_remaining == 8'd1 && stereo) begin
            channel_select_next = !channel_select;
          end
        end else if (!predictors_loaded && !load_ok) begin
          res_status = vdad_pkg::ST_STARVED;
        end else begin
          // preload sticks even if the code behind it is short
          predictor_next[0]      = p0_eff;
          predictor_next[1]      = p1_eff;
          predictors_loaded_next = 1'b1;
          bit_buffer_next        = buf_ld;
          bits_held_next         = held_ld;
          if (!code.ok) begin
            res_status = vdad_pkg::ST_STARVED;
          end else begin
            bit_buffer_next                = buf_ld >> code.pos;
            bits_held_next                 = held_ld - HELD_W'(code.pos);
            predictor_next[channel_select] = s_new;
            run_remaining_next             = code.run;
            res_sample                     = s_new;
            res_status                     = vdad_pkg::ST_SAMPLE;
            res_last                       = emit_last;
            samples_emitted_next           = emit_count;
            if (code.run == 8'd0 && stereo) begin
              channel_select_next = !channel_select;
            end
          end
        end
      end
      default: begin
        // unknown mode: no change
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_cfg <= '0;
      stereo    <= 1'b0;
      zero_runs <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vdad_pkg::REG_LEVEL:     level_cfg <= cfg_data;
        vdad_pkg::REG_STEREO:    stereo    <= cfg_data[0];
        vdad_pkg::REG_ZERO_RUNS: zero_runs <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: advance unless the result is stuck
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_mode    <= mode;
      stage_byte    <= data_byte;
      stage_samples <= unit_samples;
    end
  end

  // Unit state: update once per beat moved into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer        <= '0;
      bits_held         <= '0;
      predictor         <= '0;
      channel_select    <= 1'b0;
      run_remaining     <= '0;
      samples_emitted   <= '0;
      unit_length       <= '0;
      predictors_loaded <= 1'b0;
    end else if (fire) begin
      bit_buffer        <= bit_buffer_next;
      bits_held         <= bits_held_next;
      predictor         <= predictor_next;
      channel_select    <= channel_select_next;
      run_remaining     <= run_remaining_next;
      samples_emitted   <= samples_emitted_next;
      unit_length       <= unit_length_next;
      predictors_loaded <= predictors_loaded_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample <= res_sample;
      status <= res_status;
      last   <= res_last;
    end
  end

  // Checks
  `VDAD_ASSERT_NOW(a_held_bound, 1'b1, bits_held <= HELD_W'(BIT_BUFFER_BITS), "bit count past buffer size")
  `VDAD_ASSERT_NOW(a_count_bound, 1'b1, samples_emitted <= unit_length, "emitted past unit length")
  `VDAD_ASSERT_NOW(a_run_loaded, run_remaining != 8'd0, predictors_loaded, "run pending before preload")
  `VDAD_ASSERT_NOW(a_quiet_status, result_valid && status != vdad_pkg::ST_SAMPLE, sample == '0 && !last, "non-sample beat carries data")
  `VDAD_ASSERT_NEXT(a_start_clears, fire && stage_mode == vdad_pkg::MODE_START, bits_held == '0 && samples_emitted == '0 && !predictors_loaded, "start left unit state")

endmodule

FILE: tb/sv/tb_vlc_delta_audio_unit_decoder.sv
module tb_vlc_delta_audio_unit_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_BITS    = 40;
  localparam int MAX_SAMPLES = 65536;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 130;
  localparam int PHASES      = 9;

  typedef struct packed {
    logic signed [vdad_pkg::SAMPLE_W-1:0] sample;
    logic [vdad_pkg::STATUS_W-1:0]        status;
    logic                                 last;
  } pcm_beat_t;

  // Tracks the decoder state and the beats still owed by the block.
  class sample_scoreboard;
    logic [vdad_pkg::LEVEL_W-1:0] level;
    logic                         stereo_on;
    logic                         runs_on;
    logic [BUF_BITS-1:0]          bitbuf;
    int unsigned                  held;
    logic [15:0]                  pred [2];
    logic                         chan;
    int unsigned                  run_left;
    int unsigned                  emitted;
    int unsigned                  unit_len;
    logic                         loaded;
    pcm_beat_t                    awaited_beats [$];
    int unsigned                  errors;
    int unsigned                  beats_seen;
    int unsigned                  status_seen [5];

    function new();
      level     = '0;
      stereo_on = 1'b0;
      runs_on   = 1'b0;
      clear_unit();
      unit_len  = 0;
      errors    = 0;
      beats_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void clear_unit();
      bitbuf   = '0;
      held     = 0;
      pred[0]  = '0;
      pred[1]  = '0;
      chan     = 1'b0;
      run_left = 0;
      emitted  = 0;
      loaded   = 1'b0;
    endfunction

    function void write_reg(logic [vdad_pkg::CFG_IDX_W-1:0] idx,
                            logic [vdad_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        vdad_pkg::REG_LEVEL:     level = data;
        vdad_pkg::REG_STEREO:    stereo_on = data[0];
        vdad_pkg::REG_ZERO_RUNS: runs_on = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return awaited_beats.size();
    endfunction

    // Read n bits at offset pos, LSB first; fail if not all are held.
    function bit take(inout int unsigned pos, input int unsigned n, output logic [15:0] val);
      logic [BUF_BITS-1:0] mask;
      val = '0;
      if (pos + n > held) return 1'b0;
      mask = (BUF_BITS'(1) << n) - BUF_BITS'(1);
      val  = 16'((bitbuf >> pos) & mask);
      pos += n;
      return 1'b1;
    endfunction

    function void drop(int unsigned n);
      bitbuf = bitbuf >> n;
      held  -= n;
    endfunction

    // Signed-magnitude delta, scaled, added modulo 2^16.
    function logic [15:0] apply_delta(logic [15:0] s, logic [15:0] code,
                                      int unsigned bits, int unsigned shift);
      logic [31:0] mag;
      logic [15:0] d;
      mag = 32'(code) & ((32'd1 << (bits - 1)) - 32'd1);
      d   = 16'(mag << shift);
      return code[bits-1] ? s - d : s + d;
    endfunction

    function pcm_beat_t emit(logic [15:0] s);
      pcm_beat_t r;
      emitted++;
      r.sample = s;
      r.status = vdad_pkg::ST_SAMPLE;
      r.last   = (emitted == unit_len);
      return r;
    endfunction

    function pcm_beat_t decode_item(logic [vdad_pkg::MODE_W-1:0] m,
                                    logic [vdad_pkg::BYTE_W-1:0] b,
                                    logic [vdad_pkg::UNIT_W-1:0] u);
      pcm_beat_t                    r;
      logic [vdad_pkg::LEVEL_W-1:0] lv;
      logic                         c;
      bit                           ok;
      int unsigned                  pos, bits, shift, run, need;
      logic [15:0]                  ty, v, s;
      r.sample = '0;
      r.status = vdad_pkg::ST_ACCEPT;
      r.last   = 1'b0;
      lv = (level > vdad_pkg::LEVEL_MAX) ? vdad_pkg::LEVEL_MAX : level;
      if (m == vdad_pkg::MODE_START) begin
        unit_len = (u > MAX_SAMPLES) ? MAX_SAMPLES : u;
        clear_unit();
        return r;
      end
      if (m == vdad_pkg::MODE_PUSH) begin
        if (held + 8 > BUF_BITS) begin
          r.status = vdad_pkg::ST_FULL;
        end else begin
          bitbuf |= BUF_BITS'(b) << held;
          held += 8;
        end
        return r;
      end
      if (m != vdad_pkg::MODE_PULL) return r;
      if (emitted >= unit_len) begin
        run_left = 0;
        r.status = vdad_pkg::ST_DONE;
        return r;
      end
      c = chan;
      // Repeat the held sample while a run is pending
      if (run_left > 0) begin
        run_left--;
        r = emit(pred[c]);
        if (run_left == 0 && stereo_on) chan = ~chan;
        return r;
      end
      // Load predictors on the first pull that finds their bits held
      if (!loaded) begin
        need = stereo_on ? vdad_pkg::LOAD_STEREO : vdad_pkg::LOAD_MONO;
        if (held < need) begin
          r.status = vdad_pkg::ST_STARVED;
          return r;
        end
        pred[0] = bitbuf[15:0];
        if (stereo_on) pred[1] = bitbuf[31:16];
        drop(need);
        loaded = 1'b1;
      end
      pos = 0;
      run = 0;
      s   = pred[c];
      ok  = take(pos, 3, ty);
      if (ok && ty == 16'(vdad_pkg::TYPE_RUN)) begin
        if (runs_on) begin
          ok = take(pos, 1, v);
          if (ok && v == 1) ok = take(pos, 2, v);
          if (ok && v == 3) ok = take(pos, 8, v);
          if (ok) run = (v > 1) ? v - 1 : 0;
        end
      end else if (ok && ty != 16'(vdad_pkg::TYPE_BIG)) begin
        bits  = (lv >= vdad_pkg::LEVEL_SPLIT) ? 3 + lv : 5 - lv;
        shift = (lv >= vdad_pkg::LEVEL_SPLIT) ? 1 + ty : 2 + ty + lv;
        ok = take(pos, bits, v);
        if (ok) s = apply_delta(s, v, bits, shift);
      end else if (ok) begin
        ok = take(pos, 1, v);
        if (ok && v == 1) begin
          s = '0;
        end else if (ok) begin
          bits  = (lv >= vdad_pkg::LEVEL_SPLIT) ? 8 : 8 - lv;
          shift = (lv >= vdad_pkg::LEVEL_SPLIT) ? 9 : 9 + lv;
          ok = take(pos, bits, v);
          if (ok) s = apply_delta(s, v, bits, shift);
        end
      end
      if (!ok) begin
        r.status = vdad_pkg::ST_STARVED;
        return r;
      end
      drop(pos);
      pred[c]  = s;
      run_left = run;
      r = emit(s);
      if (run_left == 0 && stereo_on) chan = ~chan;
      return r;
    endfunction

    function void note_item(logic [vdad_pkg::MODE_W-1:0] m, logic [vdad_pkg::BYTE_W-1:0] b,
                            logic [vdad_pkg::UNIT_W-1:0] u);
      awaited_beats.insert(awaited_beats.size(), decode_item(m, b, u));
    endfunction

    function void check_beat(logic signed [vdad_pkg::SAMPLE_W-1:0] smp,
                             logic [vdad_pkg::STATUS_W-1:0] st, logic lst);
      pcm_beat_t want;
      beats_seen++;
      if (st < 5) status_seen[st]++;
      if (awaited_beats.size() == 0) begin
        $error("unexpected result beat: sample %0d status %0d last %0d", smp, st, lst);
        errors++;
        return;
      end
      want = awaited_beats.pop_front();
      if (smp !== want.sample) begin
        $error("sample mismatch: expected %0d actual %0d", want.sample, smp);
        errors++;
      end
      if (st !== want.status) begin
        $error("status mismatch: expected %0d actual %0d", want.status, st);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last mismatch: expected %0d actual %0d", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 item_valid;
  logic                                 item_stall;
  logic [vdad_pkg::MODE_W-1:0]          mode;
  logic [vdad_pkg::BYTE_W-1:0]          data_byte;
  logic [vdad_pkg::UNIT_W-1:0]          unit_samples;
  logic                                 cfg_write;
  logic [vdad_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [vdad_pkg::CFG_DATA_W-1:0]      cfg_data;
  logic                                 result_valid;
  logic                                 result_stall;
  logic signed [vdad_pkg::SAMPLE_W-1:0] sample;
  logic [vdad_pkg::STATUS_W-1:0]        status;
  logic                                 last;

  sample_scoreboard sb;
  bit          calm;
  bit          squeeze;
  bit          squeezed;
  int unsigned items_sent;
  int unsigned configs_run;
  int unsigned cycles;

  vlc_delta_audio_unit_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .data_byte    (data_byte),
    .unit_samples (unit_samples),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample       (sample),
    .status       (status),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_vlc_delta_audio_unit_decoder NOT OK");
      $finish;
    end
  end

  // Check every result beat as it is taken
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_beat(sample, status, last);
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_stall = !calm && ($urandom_range(0, 99) < 18);
    end
  end

  // Offer one item and hold it until the block takes it; called at a falling edge.
  task automatic send_item(input logic [vdad_pkg::MODE_W-1:0] m,
                           input logic [vdad_pkg::BYTE_W-1:0] b,
                           input logic [vdad_pkg::UNIT_W-1:0] u);
    while (!calm && $urandom_range(0, 99) < 18) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid   = 1'b1;
    mode         = m;
    data_byte    = b;
    unit_samples = u;
    do @(posedge clk); while (item_stall);
    sb.note_item(m, b, u);
    if (m != vdad_pkg::MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic push(input logic [vdad_pkg::BYTE_W-1:0] b);
    send_item(vdad_pkg::MODE_PUSH, b, vdad_pkg::UNIT_W'($urandom));
  endtask

  task automatic pull();
    send_item(vdad_pkg::MODE_PULL, vdad_pkg::BYTE_W'($urandom), vdad_pkg::UNIT_W'($urandom));
  endtask

  task automatic start(input logic [vdad_pkg::UNIT_W-1:0] u);
    send_item(vdad_pkg::MODE_START, vdad_pkg::BYTE_W'($urandom), u);
  endtask

  // Wait until every owed beat has arrived, then let the pipeline settle.
  task automatic wait_drained();
    item_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [vdad_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vdad_pkg::CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [vdad_pkg::LEVEL_W-1:0] lvl, input logic st,
                            input logic zr);
    wait_drained();
    write_reg(vdad_pkg::REG_LEVEL, lvl);
    write_reg(vdad_pkg::REG_STEREO, {2'($urandom), st});
    write_reg(vdad_pkg::REG_ZERO_RUNS, {2'($urandom), zr});
    cfg_write = 1'b0;
    configs_run++;
  endtask

  // One unit: a start, then pushes and pulls kept near the buffer's sweet spot, some noise.
  task automatic play_unit();
    int unsigned roll, cap, n;
    logic [vdad_pkg::UNIT_W-1:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 80)      len = vdad_pkg::UNIT_W'($urandom_range(1, 40));
    else if (roll < 88) len = vdad_pkg::UNIT_W'($urandom_range(41, 300));
    else if (roll < 93) len = '0;
    else if (roll < 97) len = vdad_pkg::UNIT_W'($urandom_range(MAX_SAMPLES, 131071));
    else                len = vdad_pkg::UNIT_W'($urandom);
    start(len);
    cap = $urandom_range(20, 90);
    for (n = 0; n < cap; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(vdad_pkg::MODE_W'($urandom), vdad_pkg::BYTE_W'($urandom),
                  vdad_pkg::UNIT_W'($urandom));
      end else if (sb.emitted >= sb.unit_len) begin
        // pull past the end, then close the unit
        repeat ($urandom_range(0, 2)) pull();
        break;
      end else if (sb.held <= 16) begin
        push(vdad_pkg::BYTE_W'($urandom));
      end else if (sb.held > 32) begin
        pull();
      end else if ($urandom_range(0, 99) < 35) begin
        push(vdad_pkg::BYTE_W'($urandom));
      end else begin
        pull();
      end
    end
  endtask

  initial begin
    logic [vdad_pkg::LEVEL_W-1:0] lvl_tab [PHASES];
    logic                         st_tab  [PHASES];
    logic                         zr_tab  [PHASES];
    int unsigned                  p, phase_start;
    sb = new();
    lvl_tab = '{3'd0, 3'd5, 3'd7, 3'd6, 3'd2, 3'd3, 3'd1, 3'd4, 3'd5};
    st_tab  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    zr_tab  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    calm         = 1'b0;
    squeeze      = 1'b0;
    squeezed     = 1'b0;
    items_sent   = 0;
    configs_run  = 0;
    cycles       = 0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    mode         = '0;
    data_byte    = '0;
    unit_samples = '0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pull before any start, unknown mode, empty and oversized units
    pull();
    send_item(vdad_pkg::MODE_UNUSED, 8'hFF, 17'h1FFFF);
    start('0);
    pull();
    start(17'h1FFFF);
    // Fill the buffer to the brim, then overflow it
    push(8'h34);
    push(8'h12);
    push(8'h00);
    push(8'hFF);
    push(8'hAA);
    push(8'h55);
    repeat (4) pull();
    // Predictor loads with no code behind it, then a reset-to-zero code
    start(17'd2);
    push(8'hFF);
    push(8'hFF);
    pull();
    push(8'h0F);
    pull();
    push(8'h00);
    pull();
    pull();

    // Random phases over a spread of settings
    for (p = 0; p < PHASES; p++) begin
      if (p < 6) set_config(lvl_tab[p], st_tab[p], zr_tab[p]);
      else set_config(vdad_pkg::LEVEL_W'($urandom), 1'($urandom), 1'($urandom));
      calm    = (p == 2);
      squeeze = squeeze || (p == 4);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) play_unit();
      calm = 1'b0;
    end

    item_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d items over %0d settings, %0d result beats", items_sent,
             configs_run, sb.beats_seen);
    $display("beats: %0d samples, %0d accepted, %0d starved, %0d full, %0d unit done",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.errors == 0) begin
      $display("tb_vlc_delta_audio_unit_decoder OK");
    end else begin
      $display("tb_vlc_delta_audio_unit_decoder NOT OK");
    end
    $finish;
  end

endmodule
